FILE: rtl/svau_pkg.sv
// ============================================================================
// svau_pkg: shared types and constants of the snapshot versioned array
// command codes, status codes and the control/status bundles between the
// sequencer and the datapath
// ============================================================================
`default_nettype none

package svau_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int QID_W  = 16;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_SNAP = 2'd1,
        CMD_GET  = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_SNAP = 2'd1,
        RES_GET  = 2'd2,
        RES_FULL = 2'd3
    } t_res;

    typedef struct packed {
        logic clr;
        logic cap;
        logic cnt_rd;
        logic init;
        logic rd_mid;
        logic step;
        logic rd_last;
        logic wr_over;
        logic wr_app;
        logic res_load;
        t_res res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic idx_ok;
        t_cmd cmd;
        logic lo_lt_hi;
        logic lo_zero;
        logic snap_match;
        logic lo_full;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/svau_in_if.sv
// ============================================================================
// svau_in_if: command channel
// valid/ready handshake carrying one command word
// ============================================================================
`default_nettype none

interface svau_in_if import svau_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]  write_value;
    logic [QID_W-1:0]         snapshot_id;

    modport source (output valid, command, entry_index, write_value, snapshot_id,
                    input ready);
    modport sink   (input valid, command, entry_index, write_value, snapshot_id,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/svau_out_if.sv
// ============================================================================
// svau_out_if: result channel
// valid/ready handshake carrying one result word
// ============================================================================
`default_nettype none

interface svau_out_if import svau_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  read_value;
    logic [QID_W-1:0]         snap_taken;
    logic [STAT_W-1:0]        status;

    modport source (output valid, read_value, snap_taken, status, input ready);
    modport sink   (input valid, read_value, snap_taken, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/snapshot_versioned_array_unit.sv
// ============================================================================
// snapshot_versioned_array_unit: versioned word array with snapshots
// set, snap and get commands over ENTRIES words of VERSIONS versions each
// ============================================================================
// sequencing: snap and no-op load the result at dispatch; set and get read the
//   version count and run a binary search, reading the single-port version
//   store once per search step
// throughput: one word at a time; the next word is taken when the block is idle
// reset: synchronous; afterwards a sweep clears the version counts, one
//   entry a cycle, with no command taken until the sweep ends
// ============================================================================
`default_nettype none

module snapshot_versioned_array_unit import svau_pkg::*; #(
    parameter int ENTRIES   = 1024,
    parameter int VERSIONS  = 16,
    parameter int SNAP_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    svau_in_if.sink   i_cmd,
    svau_out_if.source o_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    svau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    svau_dp #(
        .ENTRIES   (ENTRIES),
        .VERSIONS  (VERSIONS),
        .SNAP_BITS (SNAP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_command     (i_cmd.command),
        .i_entry_index (i_cmd.entry_index),
        .i_write_value (i_cmd.write_value),
        .i_snapshot_id (i_cmd.snapshot_id),
        .o_read_value  (o_res.read_value),
        .o_snap_taken  (o_res.snap_taken),
        .o_status      (o_res.status)
    );

endmodule

`default_nettype wire

FILE: rtl/svau_dp.sv
// ============================================================================
// svau_dp: datapath of the snapshot versioned array
// version store, per-entry version counts, snapshot counter, binary search
// bounds and the result register
// ============================================================================
`default_nettype none

module svau_dp import svau_pkg::*; #(
    parameter int ENTRIES   = 1024,
    parameter int VERSIONS  = 16,
    parameter int SNAP_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output      t_dp_sts                 o_sts,
    input  wire logic [CMD_W-1:0]        i_command,
    input  wire logic [IDX_W-1:0]        i_entry_index,
    input  wire logic signed [VAL_W-1:0] i_write_value,
    input  wire logic [QID_W-1:0]        i_snapshot_id,
    output      logic signed [VAL_W-1:0] o_read_value,
    output      logic [QID_W-1:0]        o_snap_taken,
    output      logic [STAT_W-1:0]       o_status
);

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW  = $clog2(VERSIONS + 1);
    localparam int DEPTH = ENTRIES * VERSIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (SNAP_BITS > QID_W) ? SNAP_BITS : QID_W;
    localparam int RNGW  = 18;
    localparam int SW    = SNAP_BITS + VAL_W;

    logic [SW-1:0]          r_store [DEPTH];
    logic [CNTW-1:0]        r_count [ENTRIES];

    t_cmd                   r_cmd;
    logic [IW-1:0]          r_idx;
    logic                   r_idx_ok;
    logic signed [VAL_W-1:0] r_val;
    logic [QID_W-1:0]       r_qid;
    logic [SNAP_BITS-1:0]   r_cur;
    logic [IW-1:0]          r_clr;
    logic [CNTW-1:0]        r_cnt_q;
    logic [SW-1:0]          r_st_q;
    logic [CNTW-1:0]        r_lo;
    logic [CNTW-1:0]        r_hi;
    logic [AW-1:0]          r_base;
    logic signed [VAL_W-1:0] r_read_value;
    logic [QID_W-1:0]       r_snap_taken;
    t_status                r_status;

    logic [CNTW-1:0]        mid;
    logic [AW-1:0]          addr_mid;
    logic [AW-1:0]          addr_last;
    logic [AW-1:0]          addr_next;
    logic [AW-1:0]          st_addr;
    logic [IW-1:0]          cnt_addr;
    logic [CW-1:0]          cur_ext;
    logic [SNAP_BITS-1:0]   q_snap;
    logic                   snap_max;
    logic                   q_le;

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign addr_mid  = r_base + AW'(mid);
    assign addr_last = r_base + AW'(r_lo) - AW'(1);
    assign addr_next = r_base + AW'(r_lo);
    assign cur_ext   = CW'(r_cur);
    assign q_snap    = r_st_q[SW-1:VAL_W];
    assign snap_max  = &r_cur;
    assign q_le      = CW'(q_snap) <= CW'(r_qid);

    always_comb begin
        priority if (i_cmd.rd_mid) begin
            st_addr = addr_mid;
        end else if (i_cmd.wr_app) begin
            st_addr = addr_next;
        end else begin
            st_addr = addr_last;
        end
    end

    assign cnt_addr = i_cmd.clr ? r_clr : r_idx;

    // version store, single port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_over || i_cmd.wr_app) begin
            r_store[st_addr] <= {r_cur, r_val};
        end
        if (i_cmd.rd_mid || i_cmd.rd_last) begin
            r_st_q <= r_store[st_addr];
        end
    end

    // version counts, cleared by a sweep after reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_count[cnt_addr] <= '0;
        end else if (i_cmd.wr_app) begin
            r_count[cnt_addr] <= r_lo + CNTW'(1);
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= r_count[cnt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.res_load && i_cmd.res_kind == RES_SNAP && !snap_max) begin
                r_cur <= r_cur + SNAP_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cmd    <= t_cmd'(i_command);
            r_idx    <= IW'(i_entry_index);
            r_idx_ok <= RNGW'(i_entry_index) < RNGW'(ENTRIES);
            r_val    <= i_write_value;
            r_qid    <= i_snapshot_id;
        end
        if (i_cmd.init) begin
            r_lo   <= (r_cmd == CMD_SET) ? r_cnt_q : '0;
            r_hi   <= r_cnt_q;
            r_base <= AW'(r_idx) * AW'(VERSIONS);
        end
        if (i_cmd.step) begin
            if (q_le) begin
                r_lo <= mid + CNTW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_kind)
                RES_ZERO: begin
                    r_read_value <= '0;
                    r_snap_taken <= '0;
                    r_status     <= ST_OK;
                end
                RES_SNAP: begin
                    r_read_value <= '0;
                    r_snap_taken <= snap_max ? '0 : cur_ext[QID_W-1:0];
                    r_status     <= snap_max ? ST_EXHAUSTED : ST_OK;
                end
                RES_GET: begin
                    r_read_value <= r_st_q[VAL_W-1:0];
                    r_snap_taken <= '0;
                    r_status     <= ST_OK;
                end
                RES_FULL: begin
                    r_read_value <= '0;
                    r_snap_taken <= '0;
                    r_status     <= ST_FULL;
                end
            endcase
        end
    end

    assign o_sts.clr_done   = (r_clr == IW'(ENTRIES - 1));
    assign o_sts.idx_ok     = r_idx_ok;
    assign o_sts.cmd        = r_cmd;
    assign o_sts.lo_lt_hi   = r_lo < r_hi;
    assign o_sts.lo_zero    = (r_lo == '0);
    assign o_sts.snap_match = (q_snap == r_cur);
    assign o_sts.lo_full    = (r_lo >= CNTW'(VERSIONS));

    assign o_read_value = r_read_value;
    assign o_snap_taken = r_snap_taken;
    assign o_status     = r_status;

endmodule

`default_nettype wire

FILE: rtl/svau_ctrl.sv
// ============================================================================
// svau_ctrl: sequencer of the snapshot versioned array
// runs the count clearing sweep, accepts commands, steps the binary search
// and hands results to the output register
// ============================================================================
`default_nettype none

module svau_ctrl import svau_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output      logic    o_in_ready,
    output      logic    o_out_valid,
    input  wire logic    i_out_ready,
    output      t_dp_cmd o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_INIT,
        S_SEARCH,
        S_CMP,
        S_LAST
    } t_state;

    t_state  r_state;
    logic    r_out_valid;
    logic    out_free;
    t_dp_cmd c;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        c          = '0;
        c.res_kind = RES_ZERO;
        unique case (r_state)
            S_CLEAR: begin
                c.clr = 1'b1;
            end
            S_IDLE: begin
                c.cap = i_in_valid;
            end
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_SNAP: begin
                        c.res_load = out_free;
                        c.res_kind = RES_SNAP;
                    end
                    CMD_NOP: begin
                        c.res_load = out_free;
                    end
                    CMD_SET, CMD_GET: begin
                        if (i_sts.idx_ok) begin
                            c.cnt_rd = 1'b1;
                        end else begin
                            c.res_load = out_free;
                        end
                    end
                endcase
            end
            S_INIT: begin
                c.init = 1'b1;
            end
            S_SEARCH: begin
                priority if (i_sts.lo_lt_hi) begin
                    c.rd_mid = 1'b1;
                end else if (!i_sts.lo_zero) begin
                    c.rd_last = 1'b1;
                end else begin
                    c.res_load = out_free;
                    c.wr_app   = out_free && (i_sts.cmd == CMD_SET);
                end
            end
            S_CMP: begin
                c.step = 1'b1;
            end
            S_LAST: begin
                if (out_free) begin
                    c.res_load = 1'b1;
                    priority if (i_sts.cmd == CMD_GET) begin
                        c.res_kind = RES_GET;
                    end else if (i_sts.snap_match) begin
                        c.wr_over = 1'b1;
                    end else if (i_sts.lo_full) begin
                        c.res_kind = RES_FULL;
                    end else begin
                        c.wr_app = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (c.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    if (c.cnt_rd) begin
                        r_state <= S_INIT;
                    end else if (c.res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_INIT: begin
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (c.rd_mid) begin
                        r_state <= S_CMP;
                    end else if (c.rd_last) begin
                        r_state <= S_LAST;
                    end else if (c.res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CMP: begin
                    r_state <= S_SEARCH;
                end
                S_LAST: begin
                    if (c.res_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_cmd       = c;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sim/svau_checker.sv
// ============================================================================
// svau_checker: result checker for the snapshot versioned array
// watches both channels, keeps its own copy of the version history and the
// snapshot counter, works out the result of every accepted command word and
// compares it field by field with the result words in order
// ============================================================================
`timescale 1ns / 1ps

module svau_checker import svau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    svau_in_if        i_cmd,
    svau_out_if       i_res,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int N_WORDS = 1 << IDX_W;
    localparam int N_VERS  = 16;
    localparam int MSG_CAP = 100;
    localparam logic [QID_W-1:0] SNAP_LAST = '1;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [QID_W-1:0]        snap_taken;
        t_status                 status;
    } t_outcome;

    // history entries above hist_len are never read, so only the lengths are cleared
    logic [QID_W-1:0]        hist_snap [N_WORDS][N_VERS];
    logic signed [VAL_W-1:0] hist_val  [N_WORDS][N_VERS];
    logic [4:0]              hist_len  [N_WORDS];
    logic [QID_W-1:0]        snap_now;
    t_outcome                outcome_q [$];
    int                      fail_cnt = 0;

    task automatic apply_command(input t_cmd op, input logic [IDX_W-1:0] idx,
                                 input logic signed [VAL_W-1:0] val,
                                 input logic [QID_W-1:0] qid, output t_outcome res);
        int  n;
        bit  found;
        res        = '0;
        res.status = ST_OK;
        n          = int'(hist_len[idx]);
        found      = 1'b0;
        case (op)
            CMD_SET: begin
                if (n > 0 && hist_snap[idx][n-1] == snap_now) begin
                    hist_val[idx][n-1] = val;
                end else if (n >= N_VERS) begin
                    res.status = ST_FULL;
                end else begin
                    hist_snap[idx][n] = snap_now;
                    hist_val[idx][n]  = val;
                    hist_len[idx]     = 5'(n + 1);
                end
            end
            CMD_SNAP: begin
                if (snap_now == SNAP_LAST) begin
                    res.status = ST_EXHAUSTED;
                end else begin
                    res.snap_taken = snap_now;
                    snap_now       = snap_now + 1'b1;
                end
            end
            CMD_GET: begin
                // versions are in rising snapshot order: newest one not above qid
                for (int i = n - 1; i >= 0; i--) begin
                    if (!found && hist_snap[idx][i] <= qid) begin
                        res.read_value = hist_val[idx][i];
                        found          = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        t_outcome next_res;
        bit       bad;
        if (!i_rst_n) begin
            foreach (hist_len[i]) hist_len[i] = '0;
            snap_now = '0;
            outcome_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.read_value = i_res.read_value;
                got.snap_taken = i_res.snap_taken;
                got.status     = t_status'(i_res.status);
                if (outcome_q.size() == 0) begin
                    if (fail_cnt < MSG_CAP)
                        $display("%0t: result word with nothing expected: value %0d snap %0d status %0d",
                                 $time, $signed(got.read_value), got.snap_taken, got.status);
                    fail_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    bad  = 1'b0;
                    if (got.read_value !== want.read_value) begin
                        if (fail_cnt < MSG_CAP)
                            $display("%0t: read_value expected %0d, got %0d", $time,
                                     $signed(want.read_value), $signed(got.read_value));
                        bad = 1'b1;
                    end
                    if (got.snap_taken !== want.snap_taken) begin
                        if (fail_cnt < MSG_CAP)
                            $display("%0t: snap_taken expected %0d, got %0d", $time,
                                     want.snap_taken, got.snap_taken);
                        bad = 1'b1;
                    end
                    if (got.status !== want.status) begin
                        if (fail_cnt < MSG_CAP)
                            $display("%0t: status expected %0d, got %0d", $time,
                                     want.status, got.status);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_cnt++;
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_command(t_cmd'(i_cmd.command), i_cmd.entry_index, i_cmd.write_value,
                              i_cmd.snapshot_id, next_res);
                outcome_q.push_back(next_res);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= outcome_q.size();
    end

endmodule

FILE: sim/tb.sv
// ============================================================================
// tb: testbench top for the snapshot versioned array
// drives directed and random command words with random idling on both
// channels, a long result hold-off and a full drain, and reports the
// checker's verdict
// ============================================================================
`timescale 1ns / 1ps

module tb import svau_pkg::*; ();

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 1300;
    localparam int HOT_N        = 4;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   idle_en    = 1'b1;
    bit   hold_req   = 1'b0;
    int   snaps_sent = 0;
    logic [IDX_W-1:0] hot_idx [HOT_N];

    svau_in_if  cmd_if ();
    svau_out_if res_if ();

    snapshot_versioned_array_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    svau_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_len(input int quiet_pct);
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < quiet_pct)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input t_cmd op, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val,
                             input logic [QID_W-1:0] qid);
        int gap;
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= op;
        cmd_if.entry_index <= idx;
        cmd_if.write_value <= val;
        cmd_if.snapshot_id <= qid;
        do @(posedge clk); while (!cmd_if.ready);
        if (op == CMD_SNAP)
            snaps_sent++;
        gap = idle_len(50);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random();
        int                      r;
        t_cmd                    op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic [QID_W-1:0]        qid;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = CMD_SET;
        else if (r < 55)
            op = CMD_SNAP;
        else if (r < 92)
            op = CMD_GET;
        else
            op = CMD_NOP;
        if ($urandom_range(0, 9) < 7)
            idx = hot_idx[$urandom_range(0, HOT_N - 1)];
        else
            idx = IDX_W'($urandom);
        case ($urandom_range(0, 19))
            0:       val = 32'sh7fff_ffff;
            1:       val = 32'sh8000_0000;
            2:       val = '0;
            3:       val = -32'sd1;
            default: val = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       qid = QID_W'($urandom);
            1, 2, 3: qid = QID_W'($urandom_range(0, snaps_sent + 2));
            default: qid = QID_W'($urandom_range(0, snaps_sent));
        endcase
        send_word(op, idx, val, qid);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = idle_len(70);
                if (stall > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [IDX_W-1:0] fill_idx;
        cmd_if.valid       <= 1'b0;
        cmd_if.command     <= CMD_NOP;
        cmd_if.entry_index <= '0;
        cmd_if.write_value <= '0;
        cmd_if.snapshot_id <= '0;
        rst_n              <= 1'b0;
        foreach (hot_idx[i]) hot_idx[i] = IDX_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty word, overwrite within a snapshot, extremes, query beyond counter
        send_word(CMD_GET,  10'd0,    32'sd0,          16'd0);
        send_word(CMD_SET,  10'd0,    32'sh7fff_ffff,  16'd0);
        send_word(CMD_SET,  10'd0,    32'sh8000_0000,  16'd0);
        send_word(CMD_SET,  10'd1023, -32'sd1,         16'd0);
        send_word(CMD_GET,  10'd0,    32'sd0,          16'd0);
        send_word(CMD_GET,  10'd1023, 32'sd0,          16'hffff);
        send_word(CMD_SNAP, 10'd1023, -32'sd1,         16'hffff);
        send_word(CMD_SET,  10'd0,    32'sd5,          16'd0);
        send_word(CMD_GET,  10'd0,    32'sd0,          16'd0);
        send_word(CMD_GET,  10'd0,    32'sd0,          16'd1);
        send_word(CMD_NOP,  10'd1023, -32'sd1,         16'hffff);
        send_word(CMD_SNAP, 10'd0,    32'sd0,          16'd0);
        send_word(CMD_GET,  10'd0,    32'sd0,          16'd2);
        send_word(CMD_SET,  10'd512,  32'sd0,          16'd0);
        send_word(CMD_GET,  10'd512,  32'sd0,          16'd1);
        send_word(CMD_GET,  10'd512,  32'sd0,          16'd2);
        send_word(CMD_GET,  10'd1023, 32'sd0,          16'd0);
        send_word(CMD_NOP,  10'd0,    32'sd0,          16'd0);

        // fill one word's version list past its end
        fill_idx = IDX_W'($urandom);
        repeat (17) begin
            send_word(CMD_SET, fill_idx, $urandom, QID_W'($urandom));
            send_word(CMD_SNAP, IDX_W'($urandom), $urandom, QID_W'($urandom));
        end
        send_word(CMD_SET, fill_idx, $urandom, '0);
        repeat (4)
            send_word(CMD_GET, fill_idx, $urandom, QID_W'($urandom_range(0, snaps_sent)));

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == 400)
                hold_req = 1'b1;
            if (k == 800)
                wait_drained();
            idle_en = !(k >= 1000 && k < 1100);
            send_random();
        end

        send_word(CMD_SET, hot_idx[0], $urandom, '0);
        send_word(CMD_GET, hot_idx[0], '0, 16'hffff);
        send_word(CMD_GET, hot_idx[0], '0, 16'hfffe);
        send_word(CMD_SNAP, hot_idx[1], '0, '0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
